// ===== hw/rtl/chks_pkg.sv =====
// ----------------------------------------------------------------------------
// chks_pkg
// Shared types, constants and hash helpers for the chained hash key set.
// ----------------------------------------------------------------------------
`default_nettype none

package chks_pkg;

    // field widths fixed by the block definition
    localparam int KEY_W  = 32;
    localparam int FILL_W = 4;
    localparam int CFG_W  = 11;

    // bucket count register after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // integer mix constants
    localparam logic [KEY_W-1:0] WANG_XOR = 32'd61;
    localparam logic [KEY_W-1:0] WANG_MUL = 32'h27d4eb2d;
    localparam int WANG_SH_A = 16;
    localparam int WANG_SH_B = 3;
    localparam int WANG_SH_C = 4;
    localparam int WANG_SH_D = 15;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MOD_GO,
        S_MOD_WAIT,
        S_FILL_RD,
        S_FILL_CHK,
        S_SCAN,
        S_RESP
    } t_state;

    // mix steps ahead of the multiply
    function automatic logic [KEY_W-1:0] wang_premix(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = (k ^ WANG_XOR) ^ (k >> WANG_SH_A);
        h = h + (h << WANG_SH_B);
        h = h ^ (h >> WANG_SH_C);
        return h;
    endfunction

    // mix step after the multiply
    function automatic logic [KEY_W-1:0] wang_final(input logic [KEY_W-1:0] h);
        return h ^ (h >> WANG_SH_D);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/chks_if.sv =====
// ----------------------------------------------------------------------------
// chks_req_if / chks_rsp_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface chks_req_if;
    import chks_pkg::*;
    logic             valid;
    logic             ready;
    logic             action;
    logic [KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

interface chks_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic status;

    modport source (output valid, output found, output status, input ready);
    modport sink   (input valid, input found, input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/chks_ram.sv =====
// ----------------------------------------------------------------------------
// chks_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module chks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/chks_mod.sv =====
// ----------------------------------------------------------------------------
// chks_mod
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module chks_mod
    import chks_pkg::*;
#(
    parameter int DW = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [KEY_W-1:0] i_dividend,
    input  wire logic [DW-1:0]    i_divisor,
    output logic                  o_done,
    output logic      [DW-1:0]    o_rem
);

    localparam int CNT_W = $clog2(KEY_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEY_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0] r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;

    logic [DW:0] trial;
    logic        fits;

    // shift in the next dividend bit and try a subtract
    assign trial = {r_rem, r_quo[KEY_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[KEY_W-2:0], 1'b0};
            r_rem <= fits ? DW'(trial - {1'b0, r_div}) : DW'(trial);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== hw/rtl/chks_ctrl.sv =====
// ----------------------------------------------------------------------------
// chks_ctrl
// Sequencer: hashes a word, reads the bucket fill, appends or scans the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module chks_ctrl
    import chks_pkg::*;
#(
    parameter int BUCKETS     = 1024,
    parameter int CHAIN_DEPTH = 8,
    parameter int BW          = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    parameter int KAW         = (BUCKETS * CHAIN_DEPTH > 1) ?
                                $clog2(BUCKETS * CHAIN_DEPTH) : 1,
    parameter int DW          = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    chks_req_if.sink               i_req,
    chks_rsp_if.source             o_rsp,
    // remainder unit
    output logic                   o_mod_start,
    output logic      [KEY_W-1:0]  o_mod_dividend,
    input  wire logic              i_mod_done,
    input  wire logic [DW-1:0]     i_mod_rem,
    // fill memory
    output logic                   o_fill_we,
    output logic      [BW-1:0]     o_fill_waddr,
    output logic      [FILL_W-1:0] o_fill_wdata,
    output logic      [BW-1:0]     o_fill_raddr,
    input  wire logic [FILL_W-1:0] i_fill_rdata,
    // key memory
    output logic                   o_key_we,
    output logic      [KAW-1:0]    o_key_waddr,
    output logic      [KEY_W-1:0]  o_key_wdata,
    output logic      [KAW-1:0]    o_key_raddr,
    input  wire logic [KEY_W-1:0]  i_key_rdata
);

    localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(CHAIN_DEPTH);
    localparam logic [KAW-1:0]    DEPTH_A  = KAW'(CHAIN_DEPTH);
    localparam logic [BW-1:0]     CLR_LAST = BW'(BUCKETS - 1);

    t_state r_state;
    t_state n_state;

    logic              r_action;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_h;
    logic [BW-1:0]     r_bucket;
    logic [KAW-1:0]    r_base;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_ridx;
    logic              r_pend;
    logic [BW-1:0]     r_clr_addr;
    logic              r_found;
    logic              r_status;
    logic              r_out_valid;
    logic              r_out_found;
    logic              r_out_status;

    logic [FILL_W-1:0] fill_now;
    logic              room;
    logic              hit;
    logic              scan_end;
    logic              req_take;
    logic              rsp_load;

    // fill as read, held to the chain depth
    assign fill_now = (i_fill_rdata > DEPTH_F) ? DEPTH_F : i_fill_rdata;
    assign room     = (fill_now < DEPTH_F);
    assign hit      = r_pend && (i_key_rdata == r_key);
    assign scan_end = (r_ridx == r_fill);
    assign req_take = i_req.valid && i_req.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (req_take) n_state = S_MUL;
            end
            S_MUL:      n_state = S_MOD_GO;
            S_MOD_GO:   n_state = S_MOD_WAIT;
            S_MOD_WAIT: begin
                if (i_mod_done) n_state = S_FILL_RD;
            end
            S_FILL_RD:  n_state = S_FILL_CHK;
            S_FILL_CHK: begin
                n_state = (r_action == ACT_SEARCH) ? S_SCAN : S_RESP;
            end
            S_SCAN: begin
                if (hit || scan_end) n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) n_state = S_IDLE;
            end
            default:    n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready    = 1'b0;
        o_mod_start    = 1'b0;
        o_mod_dividend = wang_final(r_h);
        o_fill_we      = 1'b0;
        o_fill_waddr   = r_bucket;
        o_fill_wdata   = fill_now + 1'b1;
        o_fill_raddr   = r_bucket;
        o_key_we       = 1'b0;
        o_key_waddr    = r_base + KAW'(fill_now);
        o_key_wdata    = r_key;
        o_key_raddr    = r_base + KAW'(r_ridx);
        rsp_load       = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_fill_we    = 1'b1;
                o_fill_waddr = r_clr_addr;
                o_fill_wdata = '0;
            end
            S_IDLE:   i_req.ready = 1'b1;
            S_MOD_GO: o_mod_start = 1'b1;
            S_FILL_CHK: begin
                if (r_action == ACT_INSERT && room) begin
                    o_fill_we = 1'b1;
                    o_key_we  = 1'b1;
                end
            end
            S_RESP:   rsp_load = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // response register, free to load when empty or being taken
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            // one chain read in flight while scanning
            if (r_state == S_SCAN) begin
                r_pend <= !hit && !scan_end;
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (req_take) begin
                    r_action <= i_req.action;
                    r_key    <= i_req.key;
                    r_h      <= wang_premix(i_req.key);
                    r_found  <= 1'b0;
                    r_status <= STATUS_OK;
                end
            end
            S_MUL: r_h <= r_h * WANG_MUL;
            S_MOD_WAIT: begin
                if (i_mod_done) r_bucket <= BW'(i_mod_rem);
            end
            S_FILL_RD: r_base <= KAW'(r_bucket) * DEPTH_A;
            S_FILL_CHK: begin
                r_fill <= fill_now;
                r_ridx <= '0;
                if (r_action == ACT_INSERT && !room) r_status <= STATUS_FULL;
            end
            S_SCAN: begin
                if (hit) begin
                    r_found <= 1'b1;
                end else if (!scan_end) begin
                    r_ridx <= r_ridx + 1'b1;
                end
            end
            S_RESP: begin
                if (rsp_load) begin
                    r_out_found  <= r_found;
                    r_out_status <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.found  = r_out_found;
    assign o_rsp.status = r_out_status;

endmodule

`default_nettype wire

// ===== hw/rtl/chained_hash_key_set_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_key_set_core
// Set of 32-bit keys in bounded hash chains, with insert and search.
// ----------------------------------------------------------------------------
// One word is handled at a time. The premix of the hash is registered at the
// accept and the multiply in its own state; the bit-serial remainder unit
// then reduces the hash by the bucket count (32 steps and a done strobe),
// the bucket fill is read, and for a search the stored chain entries are
// read back from the key memory one entry per cycle, stopping on a hit;
// last the response register is loaded. An insert is appended at the fill
// position, or dropped with status 1 if the chain is full. A new word is
// taken while the last response still waits; its own response then holds
// in the response state until the older one is taken. After reset the fill
// memory is cleared, one bucket per cycle, so no word is taken until every
// bucket is cleared. Write the bucket count only while idle; zero acts as
// one and values above BUCKETS act as BUCKETS.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_key_set_core
    import chks_pkg::*;
#(
    parameter int BUCKETS     = 1024,
    parameter int CHAIN_DEPTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    chks_req_if.sink              i_req,
    chks_rsp_if.source            o_rsp
);

    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int KAW = (BUCKETS * CHAIN_DEPTH > 1) ? $clog2(BUCKETS * CHAIN_DEPTH) : 1;
    localparam int DW  = $clog2(BUCKETS + 1);
    localparam int EW  = (DW > CFG_W) ? DW : CFG_W;
    localparam logic [EW-1:0] EFF_MAX = EW'(BUCKETS);

    logic [CFG_W-1:0] r_bucket_count;
    logic [EW-1:0]    cnt_ext;
    logic [EW-1:0]    eff_ext;
    logic [DW-1:0]    eff_count;

    logic              mod_start;
    logic [KEY_W-1:0]  mod_dividend;
    logic              mod_done;
    logic [DW-1:0]     mod_rem;

    logic              fill_we;
    logic [BW-1:0]     fill_waddr;
    logic [FILL_W-1:0] fill_wdata;
    logic [BW-1:0]     fill_raddr;
    logic [FILL_W-1:0] fill_rdata;

    logic              key_we;
    logic [KAW-1:0]    key_waddr;
    logic [KEY_W-1:0]  key_wdata;
    logic [KAW-1:0]    key_raddr;
    logic [KEY_W-1:0]  key_rdata;

    // bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    // modulus in use, held to one through BUCKETS
    assign cnt_ext   = EW'(r_bucket_count);
    assign eff_ext   = (cnt_ext == '0)      ? EW'(1)  :
                       (cnt_ext > EFF_MAX)  ? EFF_MAX : cnt_ext;
    assign eff_count = DW'(eff_ext);

    // hash reduction
    chks_mod #(
        .DW (DW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (eff_count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // per-bucket fill counts
    chks_ram #(
        .WIDTH (FILL_W),
        .DEPTH (BUCKETS),
        .AW    (BW)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    // chain entries
    chks_ram #(
        .WIDTH (KEY_W),
        .DEPTH (BUCKETS * CHAIN_DEPTH),
        .AW    (KAW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // sequencer
    chks_ctrl #(
        .BUCKETS     (BUCKETS),
        .CHAIN_DEPTH (CHAIN_DEPTH),
        .BW          (BW),
        .KAW         (KAW),
        .DW          (DW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .o_mod_start    (mod_start),
        .o_mod_dividend (mod_dividend),
        .i_mod_done     (mod_done),
        .i_mod_rem      (mod_rem),
        .o_fill_we      (fill_we),
        .o_fill_waddr   (fill_waddr),
        .o_fill_wdata   (fill_wdata),
        .o_fill_raddr   (fill_raddr),
        .i_fill_rdata   (fill_rdata),
        .o_key_we       (key_we),
        .o_key_waddr    (key_waddr),
        .o_key_wdata    (key_wdata),
        .o_key_raddr    (key_raddr),
        .i_key_rdata    (key_rdata)
    );

endmodule

`default_nettype wire
